// ===== sv/positional_list_engine_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the positional list engine
// Shared wrappers around concurrent assertions clocked by i_clk.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define PLE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ple_pkg.sv =====
// ---------------------------------------------------------------------------
// ple_pkg
// Types and codes shared by the positional list engine modules.
// ---------------------------------------------------------------------------
package ple_pkg;

    // Request operation codes
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // Response status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Field widths
    localparam int unsigned POS_W  = 7;
    localparam int unsigned DATA_W = 32;

    // Input word
    typedef struct packed {
        logic [1:0]               operation;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] data;
    } t_req;

    // Output word
    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] read_value;
        logic [POS_W-1:0]         length;
    } t_rsp;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD_CAP,
        S_LOOP,
        S_SH_WR,
        S_RESP
    } t_ple_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic sts_load;
        logic rd_pos;
        logic ptr_pos_init;
        logic ptr_ins_init;
        logic cap_rd;
        logic rd_shift;
        logic wr_shift;
        logic wr_ins;
        logic cnt_inc;
        logic cnt_dec;
        logic out_load;
    } t_ple_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic [1:0] status;
        logic       more;
    } t_ple_sts;

endpackage

// ===== sv/ple_ram.sv =====
// ---------------------------------------------------------------------------
// ple_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module ple_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ple_ctrl.sv =====
// ---------------------------------------------------------------------------
// ple_ctrl
// Sequencer for the list engine: decode, entry shifting and word handoff.
// ---------------------------------------------------------------------------
module ple_ctrl
    import ple_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_ple_sts i_sts,
    output t_ple_cmd o_cmd
);

    t_ple_state r_state;
    t_ple_state n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       can_load;

    // Output slot is free when empty or being drained this cycle
    assign can_load = !r_out_valid || i_out_ready;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.status != ST_DONE) begin
                    n_state = S_RESP;
                end else if (i_sts.op == OP_INSERT) begin
                    n_state = S_LOOP;
                end else begin
                    n_state = S_RD_CAP;
                end
            end
            S_RD_CAP: begin
                n_state = (i_sts.op == OP_REMOVE) ? S_LOOP : S_RESP;
            end
            S_LOOP: begin
                n_state = i_sts.more ? S_SH_WR : S_RESP;
            end
            S_SH_WR: begin
                n_state = S_LOOP;
            end
            S_RESP: begin
                if (can_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.sts_load = 1'b1;
                if (i_sts.status == ST_DONE) begin
                    if (i_sts.op == OP_INSERT) begin
                        o_cmd.ptr_ins_init = 1'b1;
                    end else begin
                        o_cmd.rd_pos       = 1'b1;
                        o_cmd.ptr_pos_init = 1'b1;
                    end
                end
            end
            S_RD_CAP: begin
                o_cmd.cap_rd = 1'b1;
            end
            S_LOOP: begin
                if (i_sts.more) begin
                    o_cmd.rd_shift = 1'b1;
                end else if (i_sts.op == OP_INSERT) begin
                    o_cmd.wr_ins  = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                end
            end
            S_SH_WR: begin
                o_cmd.wr_shift = 1'b1;
            end
            S_RESP: begin
                o_cmd.out_load = can_load;
            end
            default: o_cmd = '0;
        endcase
    end

    // Output word valid: set on load, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/ple_dp.sv =====
// ---------------------------------------------------------------------------
// ple_dp
// List datapath: request latch, entry RAM, shift pointer, count and result.
// ---------------------------------------------------------------------------
module ple_dp
    import ple_pkg::*;
#(
    parameter int unsigned DEPTH = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_req     i_req,
    input  t_ple_cmd i_cmd,
    output t_ple_sts o_sts,
    output t_rsp     o_rsp
);

    `include "positional_list_engine_assert.svh"

    localparam int unsigned AW   = $clog2(DEPTH);
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

    logic [1:0]               r_op;
    logic [POS_W-1:0]         r_pos;
    logic signed [DATA_W-1:0] r_data;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_ptr;
    logic [1:0]               r_status;
    logic signed [DATA_W-1:0] r_rd;
    t_rsp                     r_out;

    logic [CMPW-1:0]   pos_x;
    logic [CMPW-1:0]   cnt_x;
    logic [CMPW-1:0]   ptr_x;
    logic [1:0]        status;
    logic              is_ins;
    logic              more;
    logic [CW-1:0]     ptr_up;
    logic [CW-1:0]     ptr_dn;
    logic [CW-1:0]     src;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // Compare at a common width
    assign pos_x  = CMPW'(r_pos);
    assign cnt_x  = CMPW'(r_count);
    assign ptr_x  = CMPW'(r_ptr);
    assign is_ins = (r_op == OP_INSERT);

    // Check the latched request against the current length
    always_comb begin
        status = ST_RANGE;
        unique case (r_op)
            OP_READ, OP_REMOVE: begin
                status = (pos_x < cnt_x) ? ST_DONE : ST_RANGE;
            end
            OP_INSERT: begin
                if (pos_x > cnt_x) begin
                    status = ST_RANGE;
                end else if (r_count == CW'(DEPTH)) begin
                    status = ST_FULL;
                end else begin
                    status = ST_DONE;
                end
            end
            default: status = ST_RANGE;
        endcase
    end

    // Pointer is the destination of the next move
    assign ptr_up = r_ptr + 1'b1;
    assign ptr_dn = r_ptr - 1'b1;
    assign src    = is_ins ? ptr_dn : ptr_up;
    assign more   = is_ins ? (ptr_x > pos_x) : (ptr_up < r_count);

    assign o_sts.op     = r_op;
    assign o_sts.status = status;
    assign o_sts.more   = more;

    // Entry RAM ports
    assign ram_re    = i_cmd.rd_pos || i_cmd.rd_shift;
    assign ram_raddr = i_cmd.rd_pos ? AW'(r_pos) : AW'(src);
    assign ram_we    = i_cmd.wr_shift || i_cmd.wr_ins;
    assign ram_waddr = i_cmd.wr_ins ? AW'(r_pos) : AW'(r_ptr);
    assign ram_wdata = i_cmd.wr_ins ? r_data : ram_rdata;

    ple_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - 1'b1;
        end
    end

    // Request latch, pointer, read value and output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_req.operation;
            r_pos  <= i_req.position;
            r_data <= i_req.data;
            r_rd   <= '0;
        end
        if (i_cmd.sts_load) begin
            r_status <= status;
        end
        if (i_cmd.ptr_ins_init) begin
            r_ptr <= r_count;
        end else if (i_cmd.ptr_pos_init) begin
            r_ptr <= CW'(r_pos);
        end else if (i_cmd.wr_shift) begin
            r_ptr <= src;
        end
        if (i_cmd.cap_rd) begin
            r_rd <= ram_rdata;
        end
        if (i_cmd.out_load) begin
            r_out.status     <= r_status;
            r_out.read_value <= r_rd;
            r_out.length     <= cnt_x[POS_W-1:0];
        end
    end

    assign o_rsp = r_out;

    `PLE_ASSERT_IMP(a_cnt_bound, 1'b1, r_count <= CW'(DEPTH), "entry count above depth")
    `PLE_ASSERT_IMP(a_inc_ok, i_cmd.cnt_inc, is_ins && r_status == ST_DONE, "bad insert commit")
    `PLE_ASSERT_IMP(a_dec_ok, i_cmd.cnt_dec, r_count != '0 && r_op == OP_REMOVE, "bad remove")
    `PLE_ASSERT_NEXT(a_cnt_hold, i_cmd.load, r_count == $past(r_count), "count moved on load")

endmodule

// ===== sv/positional_list_engine.sv =====
// ---------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit words with read, insert and remove by index.
// ---------------------------------------------------------------------------
//  channel | dir | handshake              | word
//  --------+-----+------------------------+-------------------------------
//  in      | in  | i_in_valid / o_in_ready  | i_in_word  (operation, position, data)
//  out     | out | o_out_valid / i_out_ready | o_out_word (status, read_value, length)
//
//  A rejected request passes through decode to the response state; a read adds
//  a read-capture state. Insert and remove loop over the moved entries (remove
//  after a read-capture state): each moved word is one RAM read followed by one RAM write.
//  Synchronous active-low reset empties the list; no clearing pass is needed.
//  A full output register stalls the engine in its final state only.
// ---------------------------------------------------------------------------
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int unsigned DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_word,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_word
);

    t_ple_cmd cmd;
    t_ple_sts sts;

    // Sequencer
    ple_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // List storage and arithmetic
    ple_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in_word),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_out_word)
    );

endmodule

// ===== sim/ple_list_checker.sv =====
// ---------------------------------------------------------------------------
// ple_list_checker
// Watches both channels of the positional list engine. Each accepted request
// word runs through a local copy of the list, and the response it must give
// is queued. Each accepted response word is compared field by field against
// the oldest queued response.
// ---------------------------------------------------------------------------
module ple_list_checker
    import ple_pkg::*;
#(
    parameter int unsigned DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_req i_in_word,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_rsp i_out_word,
    output int   o_pending,
    output int   o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    // Local copy of the list contents and its length
    logic signed [DATA_W-1:0] slots [DEPTH];
    int unsigned              used = 0;

    // Responses still owed by the block, oldest first
    t_rsp due_rsp_q [$];
    int   mismatches = 0;

    assign o_mismatches = mismatches;

    // Apply one request to the local list and return the response it earns
    function automatic t_rsp list_update(input t_req req);
        t_rsp        rsp;
        int unsigned pos;
        int unsigned i;
        rsp.status     = ST_RANGE;
        rsp.read_value = '0;
        pos            = req.position;
        case (req.operation)
            OP_READ: begin
                if (pos < used) begin
                    rsp.read_value = slots[pos];
                    rsp.status     = ST_DONE;
                end
            end
            OP_INSERT: begin
                // range check wins over the full check
                if (pos > used) begin
                    rsp.status = ST_RANGE;
                end else if (used >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    for (i = used; i > pos; i--) begin
                        slots[i] = slots[i - 1];
                    end
                    slots[pos] = req.data;
                    used++;
                    rsp.status = ST_DONE;
                end
            end
            OP_REMOVE: begin
                if (pos < used) begin
                    rsp.read_value = slots[pos];
                    for (i = pos; i + 1 < used; i++) begin
                        slots[i] = slots[i + 1];
                    end
                    used--;
                    rsp.status = ST_DONE;
                end
            end
            default: begin
                // unused code: rejected as out of range, list untouched
            end
        endcase
        rsp.length = POS_W'(used);
        return rsp;
    endfunction

    // Queue a response per accepted request, check each accepted response
    always @(posedge i_clk) begin : track
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            used = 0;
            due_rsp_q.delete();
            o_pending <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                due_rsp_q.push_back(list_update(i_in_word));
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_word;
                if (due_rsp_q.size() == 0) begin
                    $display("%0t: unexpected word: expected none, actual status %0d value %0d length %0d",
                             $time, got.status, got.read_value, got.length);
                    mismatches++;
                end else begin
                    want = due_rsp_q.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, got.status);
                        mismatches++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $display("%0t: read_value mismatch: expected %0d, actual %0d",
                                 $time, want.read_value, got.read_value);
                        mismatches++;
                    end
                    if (got.length !== want.length) begin
                        $display("%0t: length mismatch: expected %0d, actual %0d",
                                 $time, want.length, got.length);
                        mismatches++;
                    end
                end
            end
            o_pending <= due_rsp_q.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Drives request words into the positional list engine: a directed pass over
// empty, short and boundary cases, then random traffic that fills the list
// to capacity, churns it and drains it again. Both channels idle in random
// bursts. The checker beside the block reports mismatches for the verdict.
// ---------------------------------------------------------------------------
module tb_top
    import ple_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LIST_DEPTH   = 64;
    localparam int unsigned RANDOM_ITEMS = 550;
    localparam int unsigned CALM_ITEMS   = 60;
    localparam int unsigned TAIL_CYCLES  = 200;
    localparam int unsigned CYCLE_LIMIT  = 600_000;

    // Operation code the block must reject
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        PH_FILL,
        PH_MIX,
        PH_DRAIN
    } t_phase;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    t_req in_word;
    logic out_valid;
    logic out_ready;
    t_rsp out_word;
    int   pending;
    int   mismatches;

    // Stimulus steering
    int   shadow_len = 0;
    int   src_rate   = 10;
    logic calm       = 1'b0;

    always #5 clk = ~clk;

    positional_list_engine #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word)
    );

    ple_list_checker #(
        .DEPTH(LIST_DEPTH)
    ) checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_word   (in_word),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_word  (out_word),
        .o_pending   (pending),
        .o_mismatches(mismatches)
    );

    function automatic t_req req_of(input logic [1:0] op, input int pos,
                                    input logic signed [DATA_W-1:0] val);
        t_req r;
        r.operation = op;
        r.position  = POS_W'(pos);
        r.data      = val;
        return r;
    endfunction

    // Build a random request word, biased by phase toward the useful range
    function automatic t_req pick_request(input t_phase ph, input int len);
        t_req r;
        int   dice;
        int   ins_pct;
        int   rd_pct;
        case (ph)
            PH_FILL: begin
                ins_pct = 78;
                rd_pct  = 10;
            end
            PH_DRAIN: begin
                ins_pct = 10;
                rd_pct  = 10;
            end
            default: begin
                ins_pct = 34;
                rd_pct  = 32;
            end
        endcase
        dice = $urandom_range(0, 99);
        if (dice < ins_pct)               r.operation = OP_INSERT;
        else if (dice < ins_pct + rd_pct) r.operation = OP_READ;
        else if (dice < 97)               r.operation = OP_REMOVE;
        else                              r.operation = OP_UNUSED;

        // mostly valid positions, some boundary hits, some noise
        dice = $urandom_range(0, 99);
        if (dice < 12)                      r.position = POS_W'($urandom_range(0, 127));
        else if (dice < 20)                 r.position = POS_W'(len);
        else if (r.operation == OP_INSERT)  r.position = POS_W'($urandom_range(0, len));
        else if (len > 0)                   r.position = POS_W'($urandom_range(0, len - 1));
        else                                r.position = '0;

        case ($urandom_range(0, 15))
            0:       r.data = 32'sh8000_0000;
            1:       r.data = 32'sh7FFF_FFFF;
            2:       r.data = '0;
            3:       r.data = '1;
            default: r.data = $urandom();
        endcase
        return r;
    endfunction

    // Offer one word, optionally after an idle burst, and hold until taken
    task automatic send_word(input t_req w);
        int gap;
        if (!calm && $urandom_range(0, 99) < src_rate) begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        // track the list length to steer positions
        case (w.operation)
            OP_INSERT: if (w.position <= shadow_len && shadow_len < LIST_DEPTH) shadow_len++;
            OP_REMOVE: if (w.position < shadow_len) shadow_len--;
            default: ;
        endcase
    endtask

    // Drop valid and hold until every owed response has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Stall the response side in random bursts, with quiet stretches
    initial begin : sink_pacing
        int burst;
        int rate;
        int tick;
        out_ready <= 1'b1;
        rate = 10;
        tick = 0;
        forever begin
            @(posedge clk);
            tick++;
            if (tick % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0:       rate = 0;
                    1:       rate = 8;
                    default: rate = 25;
                endcase
            end
            if (!calm && $urandom_range(0, 99) < rate) begin
                burst = $urandom_range(1, 18);
                out_ready <= 1'b0;
                repeat (burst) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // End the run if it hangs
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("[positional_list_engine] ERROR");
        $finish;
    end

    initial begin : stimulus
        int     issued;
        int     hold;
        t_phase phase;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_word  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every access is out of range, insert beyond end too
        send_word(req_of(OP_READ,   0, 32'sd0));
        send_word(req_of(OP_REMOVE, 0, 32'sd0));
        send_word(req_of(OP_UNUSED, 0, 32'sd0));
        send_word(req_of(OP_INSERT, 1, 32'sd5));
        // insert at the head of an empty list, then build with extremes
        send_word(req_of(OP_INSERT, 0, 32'sh8000_0000));
        send_word(req_of(OP_INSERT, 1, 32'sh7FFF_FFFF));
        send_word(req_of(OP_INSERT, 0, -32'sd1));
        send_word(req_of(OP_INSERT, 3, 32'sd0));
        send_word(req_of(OP_INSERT, 2, 32'sh5A5A_A5A5));
        send_word(req_of(OP_INSERT, 6, 32'sd7));
        // reads at both ends, past the end and at the top position
        send_word(req_of(OP_READ,   0, 32'sd0));
        send_word(req_of(OP_READ,   4, 32'sd0));
        send_word(req_of(OP_READ,   5, 32'sd0));
        send_word(req_of(OP_READ,   127, 32'sd0));
        send_word(req_of(OP_REMOVE, 127, 32'sd0));
        send_word(req_of(OP_UNUSED, 127, -32'sd1));
        send_word(req_of(OP_INSERT, 127, 32'sd9));
        // remove from the middle, the tail and the head
        send_word(req_of(OP_REMOVE, 2, 32'sd0));
        send_word(req_of(OP_REMOVE, 3, 32'sd0));
        send_word(req_of(OP_REMOVE, 0, 32'sd0));
        send_word(req_of(OP_READ,   1, 32'sd0));
        send_word(req_of(OP_REMOVE, 1, 32'sd0));
        send_word(req_of(OP_REMOVE, 0, 32'sd0));
        send_word(req_of(OP_REMOVE, 0, 32'sd0));

        // random traffic cycling through fill, churn and drain
        phase  = PH_FILL;
        hold   = 0;
        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            if (issued % 32 == 0) begin
                case ($urandom_range(0, 2))
                    0:       src_rate = 0;
                    1:       src_rate = 10;
                    default: src_rate = 30;
                endcase
            end
            if (issued == RANDOM_ITEMS / 2) wait_drained();
            calm = (issued >= RANDOM_ITEMS - CALM_ITEMS);
            send_word(pick_request(phase, shadow_len));
            issued++;
            // advance the phase once the list is full, churned or empty
            case (phase)
                PH_FILL: begin
                    if (shadow_len == LIST_DEPTH) hold++;
                    if (hold >= 6) begin
                        phase = PH_MIX;
                        hold  = 0;
                    end
                end
                PH_MIX: begin
                    hold++;
                    if (hold >= 60) begin
                        phase = PH_DRAIN;
                        hold  = 0;
                    end
                end
                default: begin
                    if (shadow_len == 0) hold++;
                    if (hold >= 4) begin
                        phase = PH_FILL;
                        hold  = 0;
                    end
                end
            endcase
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("[positional_list_engine] OK");
        end else begin
            $display("[positional_list_engine] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/ple_pkg.sv
sv/ple_ram.sv
sv/ple_ctrl.sv
sv/ple_dp.sv
sv/positional_list_engine.sv
sim/ple_list_checker.sv
sim/tb_top.sv
